// File: sv/sha_pkg.sv
// shared types, constants and round functions for the sha-256 hasher
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // block job handed from the front to the compression engine
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } sha_job_t;

  localparam int unsigned BlockLen = 64;
  localparam int unsigned LenPos   = 56;
  localparam logic [7:0]  PadByte  = 8'h80;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// File: sv/sha_front.sv
// front end: gathers bytes, pads the tail and hands whole blocks to the job queue
`default_nettype none
module sha_front import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire sha_in_t  in_beat,
  input  wire logic     in_push,
  output logic          in_full,
  output sha_job_t      job,
  output logic          job_push,
  input  wire logic     job_full
);

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [511:0] blk_r, blk_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic         job_push_r, job_push_nxt;
  logic         fin_r, fin_nxt;
  logic         acc;

  assign in_full  = (state_r != ST_FILL) || job_full;
  assign acc      = in_push && !in_full;
  assign job      = '{block: blk_r, final_blk: fin_r};
  assign job_push = job_push_r;

  // byte packing, padding and length insertion
  always_comb begin
    logic [5:0] f;
    logic [511:0] b;
    state_nxt = state_r;
    blk_nxt = blk_r;
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    job_push_nxt = 1'b0;
    fin_nxt = fin_r;
    f = fill_r;
    b = blk_r;
    case (state_r)
      ST_FILL: begin
        if (acc) begin
          if (in_beat.has_byte) begin
            b[511 - 8*f -: 8] = in_beat.data_byte;
            bits_nxt = bits_r + 64'd8;
            if (f == 6'd63) begin
              job_push_nxt = 1'b1;
              fin_nxt = 1'b0;
            end
            f = f + 6'd1;
          end
          if (in_beat.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (!job_full) begin
          // pad byte then zeros up to the end of the block
          b[511 - 8*f -: 8] = PadByte;
          for (int i = 0; i < 64; i++) begin
            if (6'(i) > f) b[511 - 8*i -: 8] = 8'h00;
          end
          if (f >= 6'(LenPos)) begin
            job_push_nxt = 1'b1;
            fin_nxt = 1'b0;
            state_nxt = ST_LEN;
            f = 6'd0;
          end else begin
            b[63:0] = bits_r;
            job_push_nxt = 1'b1;
            fin_nxt = 1'b1;
            state_nxt = ST_FILL;
            f = 6'd0;
            bits_nxt = 64'd0;
          end
        end
      end
      ST_LEN: begin
        if (!job_full) begin
          b = {448'd0, bits_r};
          job_push_nxt = 1'b1;
          fin_nxt = 1'b1;
          state_nxt = ST_FILL;
          bits_nxt = 64'd0;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
    blk_nxt = b;
    fill_nxt = f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r <= 6'd0;
      bits_r <= 64'd0;
      job_push_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
      job_push_r <= job_push_nxt;
      fin_r <= fin_nxt;
    end
    blk_r <= blk_nxt;
  end

endmodule
`default_nettype wire

// File: sv/sha_jobq.sv
// queue of block jobs between front end and engine, holding at most one job
`default_nettype none
module sha_jobq import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire sha_job_t wr_job,
  input  wire logic     wr_push,
  output logic          full,
  output sha_job_t      rd_job,
  output logic          rd_empty,
  input  wire logic     rd_pop
);

  sha_job_t    mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  // full also covers the cycle of a push, since the front pushes the cycle after it checks
  assign full     = (cnt_r != 2'd0) || wr_push;
  assign rd_empty = (cnt_r == 2'd0);
  assign rd_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_push) wp_r <= ~wp_r;
      if (rd_pop && !rd_empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_push) - 2'(rd_pop && !rd_empty);
    end
    if (wr_push) mem_r[wp_r] <= wr_job;
  end

endmodule
`default_nettype wire

// File: sv/sha_engine.sv
// back end: 64-round compression, one round a cycle, and digest word output
`default_nettype none
module sha_engine import sha_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire sha_job_t job,
  input  wire logic     job_empty,
  output logic          job_pop,
  output sha_out_t      out_beat,
  output logic          out_empty,
  input  wire logic     out_pop
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]   state_r;
  logic [255:0] h_r, dig_r;
  logic [31:0]  w_r [16];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  logic [5:0]   rnd_r;
  logic         fin_r;
  logic [2:0]   widx_r;
  logic [31:0]  wi, s0, s1, ch, mj, t1, t2, sg0, sg1, wn;

  assign job_pop   = (state_r == ST_IDLE) && !job_empty;
  assign out_empty = (state_r != ST_OUT);
  assign out_beat  = '{digest_word: dig_r[255 - 32*widx_r -: 32],
                       word_index: widx_r, last_word: widx_r == 3'd7};

  // schedule and round datapath
  always_comb begin
    sg0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    sg1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn  = w_r[0] + sg0 + w_r[9] + sg1;
    wi  = w_r[0];
    s1  = rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25);
    ch  = (e_r & f_r) ^ (~e_r & g_r);
    t1  = hh_r + s1 + ch + round_k(rnd_r) + wi;
    s0  = rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22);
    mj  = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    t2  = s0 + mj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h_r <= InitH;
      rnd_r <= 6'd0;
      widx_r <= 3'd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!job_empty) begin
            state_r <= ST_RUN;
            rnd_r <= 6'd0;
          end
        end
        ST_RUN: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= ST_ADD;
        end
        ST_ADD: begin
          if (fin_r) begin
            widx_r <= 3'd0;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_IDLE;
          end
          h_r <= fin_r ? InitH :
                 {h_r[255:224] + a_r, h_r[223:192] + b_r, h_r[191:160] + c_r,
                  h_r[159:128] + d_r, h_r[127:96] + e_r, h_r[95:64] + f_r,
                  h_r[63:32] + g_r, h_r[31:0] + hh_r};
        end
        ST_OUT: begin
          if (out_pop) begin
            widx_r <= widx_r + 3'd1;
            if (widx_r == 3'd7) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    // payload registers
    if (state_r == ST_IDLE && !job_empty) begin
      for (int i = 0; i < 16; i++) w_r[i] <= job.block[511 - 32*i -: 32];
      fin_r <= job.final_blk;
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r} <= h_r;
    end else if (state_r == ST_RUN) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      hh_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end
    if (state_r == ST_ADD) begin
      dig_r <= {h_r[255:224] + a_r, h_r[223:192] + b_r, h_r[191:160] + c_r,
                h_r[159:128] + d_r, h_r[127:96] + e_r, h_r[95:64] + f_r,
                h_r[63:32] + g_r, h_r[31:0] + hh_r};
    end
  end

endmodule
`default_nettype wire

// File: sv/sha256_message_hasher_top.sv
// top level of the sha-256 message hasher
// One byte beat per cycle enters the front end; every 64 bytes (and one or two padded
// blocks after the last beat) form a block job for the engine, which loads the job, runs 64 rounds
// at one round a cycle and then does a chaining add. The round loop sets the pace, so a
// long message sustains near one byte per cycle once a block is queued; input stalls
// for the cycle a block is handed over, while one block waits behind the one in the
// engine, and while the tail is padded.
// After the last beat the eight digest words appear in order h0..h7, the last one flagged.
`default_nettype none
module sha256_message_hasher_top import sha_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire sha_in_t in_data,
  input  wire logic    push,
  output logic         full,
  output sha_out_t     out_data,
  output logic         empty,
  input  wire logic    pop
);

  sha_job_t fj, qj;
  logic     fpush, qfull, qempty, qpop;

  // byte gathering and padding
  sha_front u_front (.clk, .rst_n, .in_beat(in_data), .in_push(push), .in_full(full),
                     .job(fj), .job_push(fpush), .job_full(qfull));

  // block job queue
  sha_jobq u_jobq (.clk, .rst_n, .wr_job(fj), .wr_push(fpush), .full(qfull),
                   .rd_job(qj), .rd_empty(qempty), .rd_pop(qpop));

  // compression engine
  sha_engine u_engine (.clk, .rst_n, .job(qj), .job_empty(qempty), .job_pop(qpop),
                       .out_beat(out_data), .out_empty(empty), .out_pop(pop));

endmodule
`default_nettype wire

// File: sv/sha_checker.sv
// port checker for the sha-256 hasher, bound to the top level
`default_nettype none
module sha_checker import sha_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire sha_out_t out_data,
  input wire logic     empty,
  input wire logic     pop
);

  // flag on the eighth word only
  a_lastw: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last_word mismatch");

  // words advance in order on each pop
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_data.last_word) |=>
      (!empty && out_data.word_index == $past(out_data.word_index) + 3'd1))
    else $error("word order broken");

  // an unpopped beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result beat changed");

  // digest always starts at word zero
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> out_data.word_index == 3'd0)
    else $error("digest not starting at h0");

endmodule

bind sha256_message_hasher_top sha_checker u_chk (.*);
`default_nettype wire
